FILE: hw/rtl/somo_pkg.sv
package somo_pkg;

   // fixed sizes
   localparam int NUM_OSC       = 3;
   localparam int OSC_SEL_W     = 2;
   localparam int SEQ_CNT_W     = 3;
   localparam int PHASE_W       = 32;
   localparam int WEIGHT_W      = 16;
   localparam int MIX_FRAC_BITS = 15;
   localparam int REQ_DATA_W    = 3 * PHASE_W;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 32;

   // parameter defaults
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF     = 16;

   // sequencer step that saturates and hands out the word
   localparam logic [SEQ_CNT_W-1:0] SEQ_SAT = SEQ_CNT_W'(NUM_OSC + 1);

   // request kinds (tuser)
   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_OSC1   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_OSC2   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_OSC1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_OSC2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_OSC0 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_OSC1 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_WEIGHT_OSC2 = 3'd6;

   // register reset values
   localparam logic [PHASE_W-1:0]         STEP_OSC1_RST = 32'd59055800;
   localparam logic [PHASE_W-1:0]         STEP_OSC2_RST = 32'd78741067;
   localparam logic signed [WEIGHT_W-1:0] WEIGHT_RST    = 16'sd10923;

   typedef struct packed {
      logic clear;   // zero the accumulator
      logic acc_en;  // add this cycle's product
      logic negate;  // lower half of the wave
   } somo_mix_ctrl_type;

   function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
      return (a * b) >> 30;
   endfunction

   // quarter-wave entry k: odd 9th-order polynomial in Q30, scaled to sample range
   function automatic logic [63:0] quarter_sine(int k, int table_bits, int sample_bits);
      logic [63:0] amp;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] p;
      logic [63:0] s;
      logic [63:0] v;
      amp = (64'd1 << (sample_bits - 1)) - 64'd1;
      t   = 64'(k) << (30 - table_bits);
      t2  = mul_q30(t, t);
      p   = 64'd5027000 - mul_q30(t2, 64'd172272);
      p   = 64'd85569347 - mul_q30(t2, p);
      p   = 64'd693598112 - mul_q30(t2, p);
      p   = 64'd1686629713 - mul_q30(t2, p);
      s   = mul_q30(t, p);
      v   = (s * amp + (64'd1 << 29)) >> 30;
      if (v > amp) begin
         v = amp;
      end
      return v;
   endfunction

endpackage

FILE: hw/rtl/somo_sine_rom.sv
module somo_sine_rom #(
   parameter int TABLE_BITS  = somo_pkg::SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS = somo_pkg::SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic [TABLE_BITS:0]    addr,
   output logic [SAMPLE_BITS-2:0] rd_data
);
   import somo_pkg::*;

   localparam int DEPTH = (1 << TABLE_BITS) + 1;
   localparam int ROM_W = SAMPLE_BITS - 1;

   logic [ROM_W-1:0] rom_table [0:DEPTH-1];
   logic [ROM_W-1:0] rd_data_ff;
   logic [ROM_W-1:0] rd_data_in;

   for (genvar k = 0; k < DEPTH; k++) begin : g_rom
      localparam logic [ROM_W-1:0] ENTRY = ROM_W'(quarter_sine(k, TABLE_BITS, SAMPLE_BITS));
      assign rom_table[k] = ENTRY;
   end

   assign rd_data_in = rom_table[addr];

   always_ff @(posedge clock) begin
      rd_data_ff <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/somo_mix_unit.sv
module somo_mix_unit #(
   parameter int SAMPLE_BITS = somo_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                  clock,
   input  somo_pkg::somo_mix_ctrl_type           ctrl,
   input  logic [SAMPLE_BITS-2:0]                rom_value,
   input  logic signed [somo_pkg::WEIGHT_W-1:0]  weight,
   output logic signed [SAMPLE_BITS-1:0]         sample,
   output logic                                  clip
);
   import somo_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + WEIGHT_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int RND_W  = ACC_W - MIX_FRAC_BITS;

   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (MIX_FRAC_BITS - 1);
   localparam logic signed [RND_W-1:0] SAT_MAX = {{(RND_W - SAMPLE_BITS + 1){1'b0}},
                                                  {(SAMPLE_BITS - 1){1'b1}}};
   localparam logic signed [RND_W-1:0] SAT_MIN = {{(RND_W - SAMPLE_BITS + 1){1'b1}},
                                                  {(SAMPLE_BITS - 1){1'b0}}};

   logic signed [SAMPLE_BITS-1:0] mag;
   logic signed [SAMPLE_BITS-1:0] sine_val;
   logic signed [PROD_W-1:0]      prod;
   logic signed [ACC_W-1:0]       acc_ff;
   logic signed [ACC_W-1:0]       acc_in;
   logic signed [ACC_W-1:0]       biased;
   logic signed [RND_W-1:0]       rounded;

   always_comb begin
      mag      = $signed({1'b0, rom_value});
      sine_val = ctrl.negate ? -mag : mag;
      prod     = PROD_W'(sine_val) * PROD_W'(weight);
      acc_in   = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + ACC_W'(prod);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // round half up, then clamp to sample range
   always_comb begin
      biased  = acc_ff + ROUND_BIAS;
      rounded = RND_W'(biased >>> MIX_FRAC_BITS);
      clip    = 1'b0;
      sample  = rounded[SAMPLE_BITS-1:0];
      if (rounded > SAT_MAX) begin
         sample = SAT_MAX[SAMPLE_BITS-1:0];
         clip   = 1'b1;
      end else if (rounded < SAT_MIN) begin
         sample = SAT_MIN[SAMPLE_BITS-1:0];
         clip   = 1'b1;
      end
   end

endmodule

FILE: hw/rtl/sine_oscillator_bank_mixer.sv
// Three-voice sine oscillator bank with a weighted, saturating mixer.
//
// req channel: one word per request. tuser = func (tick or load phase of
//   voice 0). tdata = step_osc0, offset_osc0, new_phase. A tick returns one
//   word on rsp; a load-phase word updates voice 0's phase and returns none.
// rsp channel: tdata = mixed sample (signed, saturated), tuser = clipped.
// csr channel: register index plus data; always ready. Write only while
//   the block is idle (no tick outstanding).
//
// Sequencing: after acceptance a tick occupies the sequencer for its steps:
//   quarter-wave ROM reads (one voice per step) overlapped with the
//   single shared multiply-accumulate, a step for the last product, and
//   a step to round and saturate into the output register. req_tready is
//   low meanwhile, so a tick is not taken until the one before is through.
//   A load-phase word does not occupy the sequencer.
// The output register lets the block take the next word while a sample
//   waits; if the sample is still not taken when the next tick finishes,
//   the sequencer holds in its final step until rsp_tready.
// Reset clears all phases, loads register defaults and empties the output.
module sine_oscillator_bank_mixer #(
   parameter int SINE_TABLE_BITS = somo_pkg::SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = somo_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [31:0] step_osc0, [63:32] offset_osc0, [95:64] new_phase
   input  logic [somo_pkg::REQ_DATA_W-1:0]        req_tdata,
   // [0] func
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [SAMPLE_BITS-1:0] sample, upper bits zero
   output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,
   // [0] clipped
   output logic                                   rsp_tuser,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [somo_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [somo_pkg::CSR_DATA_W-1:0]        csr_data
);
   import somo_pkg::*;

   localparam logic [SINE_TABLE_BITS:0] QUARTER_N = {1'b1, {SINE_TABLE_BITS{1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // per-voice state and settings
   logic [PHASE_W-1:0]         phase_ff  [NUM_OSC];
   logic [PHASE_W-1:0]         phase_in  [NUM_OSC];
   logic [PHASE_W-1:0]         step_ff   [NUM_OSC];
   logic [PHASE_W-1:0]         step_in   [NUM_OSC];
   logic [PHASE_W-1:0]         offset_ff [NUM_OSC];
   logic [PHASE_W-1:0]         offset_in [NUM_OSC];
   logic signed [WEIGHT_W-1:0] weight_ff [NUM_OSC];
   logic signed [WEIGHT_W-1:0] weight_in [NUM_OSC];

   // sequencer
   logic                 busy_ff, busy_in;
   logic [SEQ_CNT_W-1:0] cnt_ff, cnt_in;

   // lookup stage
   logic                 lk_valid_ff, lk_valid_in;
   logic                 lk_neg_ff, lk_neg_in;
   logic [OSC_SEL_W-1:0] lk_osc_ff, lk_osc_in;

   // output register
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_clip_ff, rsp_clip_in;

   logic                       req_acc;
   logic                       csr_acc;
   logic                       lookup_en;
   logic                       finish;
   logic [OSC_SEL_W-1:0]       osc_sel;
   logic [PHASE_W-1:0]         phase_sum;
   logic [SINE_TABLE_BITS-1:0] idx;
   logic [SINE_TABLE_BITS:0]   rom_addr;
   logic [SAMPLE_BITS-2:0]     rom_value;
   logic signed [SAMPLE_BITS-1:0] mix_sample;
   logic                       mix_clip;
   somo_mix_ctrl_type          mix_ctrl;

   assign req_tready = !busy_ff;
   assign csr_ready  = 1'b1;
   assign req_acc    = req_tvalid && req_tready;
   assign csr_acc    = csr_valid && csr_ready;

   // voice lookup: phase + offset, quadrant folds onto the quarter table
   always_comb begin
      lookup_en = busy_ff && (cnt_ff < SEQ_CNT_W'(NUM_OSC));
      osc_sel   = lookup_en ? cnt_ff[OSC_SEL_W-1:0] : '0;
      phase_sum = phase_ff[osc_sel] + offset_ff[osc_sel];
      idx       = phase_sum[PHASE_W-3 -: SINE_TABLE_BITS];
      rom_addr  = phase_sum[PHASE_W-2] ? (QUARTER_N - {1'b0, idx}) : {1'b0, idx};
      lk_valid_in = lookup_en;
      lk_neg_in   = phase_sum[PHASE_W-1];
      lk_osc_in   = osc_sel;
   end

   somo_sine_rom #(
      .TABLE_BITS  (SINE_TABLE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_rom (
      .clock   (clock),
      .addr    (rom_addr),
      .rd_data (rom_value)
   );

   always_comb begin
      mix_ctrl.clear  = req_acc && (req_tuser == FUNC_TICK);
      mix_ctrl.acc_en = lk_valid_ff;
      mix_ctrl.negate = lk_neg_ff;
   end

   somo_mix_unit #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mix (
      .clock     (clock),
      .ctrl      (mix_ctrl),
      .rom_value (rom_value),
      .weight    (weight_ff[lk_osc_ff]),
      .sample    (mix_sample),
      .clip      (mix_clip)
   );

   // sequencer: steps 0..NUM_OSC-1 look up voices, last step saturates
   always_comb begin
      finish  = busy_ff && (cnt_ff == SEQ_SAT) && (!rsp_tvalid_ff || rsp_tready);
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (req_acc && (req_tuser == FUNC_TICK)) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (busy_ff && (cnt_ff != SEQ_SAT)) begin
         cnt_in = cnt_ff + 1'b1;
      end

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in   = rsp_clip_ff;
      if (finish) begin
         rsp_tvalid_in = 1'b1;
         rsp_sample_in = mix_sample;
         rsp_clip_in   = mix_clip;
      end
   end

   // voice state: phase advances right after its lookup
   always_comb begin
      for (int i = 0; i < NUM_OSC; i++) begin
         phase_in[i]  = phase_ff[i];
         step_in[i]   = step_ff[i];
         offset_in[i] = offset_ff[i];
         weight_in[i] = weight_ff[i];
         if (lookup_en && (osc_sel == OSC_SEL_W'(i))) begin
            phase_in[i] = phase_ff[i] + step_ff[i];
         end
      end
      if (req_acc && (req_tuser == FUNC_LOAD)) begin
         phase_in[0] = req_tdata[3*PHASE_W-1 -: PHASE_W];
      end
      if (req_acc && (req_tuser == FUNC_TICK)) begin
         step_in[0]   = req_tdata[PHASE_W-1:0];
         offset_in[0] = req_tdata[2*PHASE_W-1 -: PHASE_W];
      end
      if (csr_acc) begin
         case (csr_index)
            CSR_STEP_OSC1:   step_in[1]   = csr_data[PHASE_W-1:0];
            CSR_STEP_OSC2:   step_in[2]   = csr_data[PHASE_W-1:0];
            CSR_OFFSET_OSC1: offset_in[1] = csr_data[PHASE_W-1:0];
            CSR_OFFSET_OSC2: offset_in[2] = csr_data[PHASE_W-1:0];
            CSR_WEIGHT_OSC0: weight_in[0] = $signed(csr_data[WEIGHT_W-1:0]);
            CSR_WEIGHT_OSC1: weight_in[1] = $signed(csr_data[WEIGHT_W-1:0]);
            CSR_WEIGHT_OSC2: weight_in[2] = $signed(csr_data[WEIGHT_W-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         cnt_ff        <= '0;
         lk_valid_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < NUM_OSC; i++) begin
            phase_ff[i]  <= '0;
            offset_ff[i] <= '0;
            weight_ff[i] <= WEIGHT_RST;
         end
         step_ff[0] <= '0;
         step_ff[1] <= STEP_OSC1_RST;
         step_ff[2] <= STEP_OSC2_RST;
      end else begin
         busy_ff       <= busy_in;
         cnt_ff        <= cnt_in;
         lk_valid_ff   <= lk_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         phase_ff      <= phase_in;
         step_ff       <= step_in;
         offset_ff     <= offset_in;
         weight_ff     <= weight_in;
      end
   end

   always_ff @(posedge clock) begin
      lk_neg_ff     <= lk_neg_in;
      lk_osc_ff     <= lk_osc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

   always_comb begin
      rsp_tvalid = rsp_tvalid_ff;
      rsp_tuser  = rsp_clip_ff;
      rsp_tdata  = '0;
      rsp_tdata[SAMPLE_BITS-1:0] = rsp_sample_ff;
   end

   // lookups only happen inside a running tick
   a_lookup_in_tick: assert property (@(posedge clock) disable iff (reset)
      lk_valid_ff |-> busy_ff)
      else $error("lookup stage active outside a tick");

   // a new sample only comes from the saturate step
   a_rsp_from_sat: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> ($past(busy_ff) && ($past(cnt_ff) == SEQ_SAT)))
      else $error("sample issued outside the saturate step");

   // a clipped sample sits on a rail
   a_clip_on_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_clip_ff) |->
         ((rsp_sample_ff == SAMPLE_MAX) || (rsp_sample_ff == SAMPLE_MIN)))
      else $error("clipped sample not at full scale");

endmodule

FILE: verif/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import somo_pkg::*;

   // ---------------------------------------------------------------------
   // sizes and run shape
   // ---------------------------------------------------------------------
   localparam int TABLE_BITS = SINE_TABLE_BITS_DEF;
   localparam int SAMPLE_W   = SAMPLE_BITS_DEF;
   localparam int RSP_W      = ((SAMPLE_W + 7) / 8) * 8;
   localparam int QUARTER    = 1 << TABLE_BITS;
   localparam longint SAMPLE_HI = (longint'(1) << (SAMPLE_W - 1)) - 1;
   localparam longint SAMPLE_LO = -SAMPLE_HI - 1;

   localparam int RAND_PHASES     = 6;
   localparam int WORDS_PER_PHASE = 73;
   localparam int SETTLE_CYCLES   = 12;      // a load word or a tick in flight drains well within this
   localparam int LONG_HOLD       = 250;     // receiver back-pressure stretch
   localparam int CYCLE_LIMIT     = 300000;

   // spare register slot, the block must ignore it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   // register values after reset
   localparam logic [31:0]        STEP1_DEFAULT  = 32'd59055800;
   localparam logic [31:0]        STEP2_DEFAULT  = 32'd78741067;
   localparam logic signed [15:0] WEIGHT_DEFAULT = 16'sd10923;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                clipped;
   } mix_word_type;

   // one line of the directed plan: either a register write or a request word
   typedef struct {
      bit                     is_csr;
      logic [CSR_INDEX_W-1:0] idx;
      logic [31:0]            val;
      logic                   func;
      logic [31:0]            step;
      logic [31:0]            offset;
      logic [31:0]            phase;
      bit                     fixed;    // expected sample typed in by hand
      logic [SAMPLE_W-1:0]    fx_sample;
      logic                   fx_clip;
   } plan_row_type;

   // ---------------------------------------------------------------------
   // DUT hookup
   // ---------------------------------------------------------------------
   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // [31:0] step_osc0, [63:32] offset_osc0, [95:64] new_phase
   logic                   req_tuser;   // [0] func
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_W-1:0]       rsp_tdata;   // [SAMPLE_W-1:0] sample
   logic                   rsp_tuser;   // [0] clipped
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   sine_oscillator_bank_mixer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------------
   // oscillator bank model
   // ---------------------------------------------------------------------
   int                    sine_tab [0:QUARTER];
   logic [31:0]           osc_phase  [NUM_OSC];
   logic [31:0]           osc_step   [NUM_OSC];
   logic [31:0]           osc_offset [NUM_OSC];
   logic signed [15:0]    osc_weight [NUM_OSC];

   mix_word_type pending_mix[$];   // samples owed by the block, oldest first
   int           fail_count;

   // tags the word on req: expected sample given by hand instead of the model
   bit                  fixed_valid;
   logic [SAMPLE_W-1:0] fixed_sample;
   logic                fixed_clip;

   bit long_hold_req;           // sender asks the receiver for a long stall

   // quarter wave: odd 9th-order polynomial in Q30, Horner from the top term down,
   // every product truncated back to Q30
   initial begin : build_sine
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] acc;
      logic [63:0] amp;
      logic [63:0] v;
      amp = 64'(SAMPLE_HI);
      for (int k = 0; k <= QUARTER; k++) begin
         t   = 64'(k) << (30 - TABLE_BITS);
         t2  = (t * t) >> 30;
         acc = 64'd172272;
         acc = 64'd5027000 - ((t2 * acc) >> 30);
         acc = 64'd85569347 - ((t2 * acc) >> 30);
         acc = 64'd693598112 - ((t2 * acc) >> 30);
         acc = 64'd1686629713 - ((t2 * acc) >> 30);
         v   = (((t * acc) >> 30) * amp + (64'd1 << 29)) >> 30;
         if (v > amp) begin
            v = amp;
         end
         sine_tab[k] = int'(v);
      end
   end

   // quadrant from the top two bits, table index below, rest dropped
   function automatic longint osc_sine(logic [31:0] ph);
      logic [1:0] quad;
      int         idx;
      longint     v;
      quad = ph[31:30];
      idx  = int'(ph[29 -: TABLE_BITS]);
      v    = quad[0] ? sine_tab[QUARTER - idx] : sine_tab[idx];
      return quad[1] ? -v : v;
   endfunction

   // one tick: mix at the current phases, then advance every phase
   function automatic mix_word_type mix_next_sample(logic [31:0] step0, logic [31:0] offset0);
      longint       acc;
      longint       r;
      mix_word_type w;
      osc_step[0]   = step0;
      osc_offset[0] = offset0;
      acc = 0;
      for (int i = 0; i < NUM_OSC; i++) begin
         acc += osc_sine(osc_phase[i] + osc_offset[i]) * longint'(osc_weight[i]);
      end
      // round half up, floor shift
      r = (acc + 64'sd16384) >>> MIX_FRAC_BITS;
      w.clipped = 1'b0;
      if (r > SAMPLE_HI) begin
         r = SAMPLE_HI;
         w.clipped = 1'b1;
      end else if (r < SAMPLE_LO) begin
         r = SAMPLE_LO;
         w.clipped = 1'b1;
      end
      w.sample = r[SAMPLE_W-1:0];
      for (int i = 0; i < NUM_OSC; i++) begin
         osc_phase[i] += osc_step[i];
      end
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // monitor: register writes, request words and result words, all at the
   // rising edge. Results are checked before the same edge's request is
   // modeled, so the queue order always matches the block.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      mix_word_type want;
      mix_word_type got;
      if (reset) begin
         for (int i = 0; i < NUM_OSC; i++) begin
            osc_phase[i]  = '0;
            osc_offset[i] = '0;
            osc_weight[i] = WEIGHT_DEFAULT;
         end
         osc_step[0] = '0;
         osc_step[1] = STEP1_DEFAULT;
         osc_step[2] = STEP2_DEFAULT;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STEP_OSC1:   osc_step[1]   = csr_data;
               CSR_STEP_OSC2:   osc_step[2]   = csr_data;
               CSR_OFFSET_OSC1: osc_offset[1] = csr_data;
               CSR_OFFSET_OSC2: osc_offset[2] = csr_data;
               CSR_WEIGHT_OSC0: osc_weight[0] = csr_data[15:0];
               CSR_WEIGHT_OSC1: osc_weight[1] = csr_data[15:0];
               CSR_WEIGHT_OSC2: osc_weight[2] = csr_data[15:0];
               default: ;   // spare slot: no effect
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.sample  = rsp_tdata[SAMPLE_W-1:0];
            got.clipped = rsp_tuser;
            if (pending_mix.size() == 0) begin
               $error("result word with no sample pending: sample %0d, clipped %0b",
                      $signed(got.sample), got.clipped);
               fail_count++;
            end else begin
               want = pending_mix.pop_front();
               if (got.sample !== want.sample) begin
                  $error("sample: expected %0d, got %0d",
                         $signed(want.sample), $signed(got.sample));
                  fail_count++;
               end
               if (got.clipped !== want.clipped) begin
                  $error("clipped: expected %0b, got %0b", want.clipped, got.clipped);
                  fail_count++;
               end
            end
         end

         if (req_tvalid && req_tready) begin
            if (req_tuser == FUNC_LOAD) begin
               osc_phase[0] = req_tdata[95:64];   // no result for a load
            end else begin
               want = mix_next_sample(req_tdata[31:0], req_tdata[63:32]);
               if (fixed_valid) begin
                  want.sample  = fixed_sample;
                  want.clipped = fixed_clip;
               end
               pending_mix.push_back(want);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // receiver: random back-pressure, free-running stretches, and one long
   // hold on request from the sender
   // ---------------------------------------------------------------------
   initial begin : rsp_side
      int stall_left;
      int free_left;
      int roll;
      stall_left = 0;
      free_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            rsp_tready <= 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            roll = $urandom_range(99);
            if (roll < 10) begin
               free_left = $urandom_range(80, 20);
               rsp_tready <= 1'b1;
            end else if (roll < 55) begin
               rsp_tready <= 1'b1;
            end else if (roll < 92) begin
               rsp_tready <= 1'b0;
               stall_left = $urandom_range(2);
            end else begin
               rsp_tready <= 1'b0;
               stall_left = $urandom_range(40, 8);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus helpers; every task is entered and left at a falling edge
   // ---------------------------------------------------------------------
   function automatic int pick_gap(bit burst);
      int roll;
      roll = $urandom_range(99);
      if (burst || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 6);
   endfunction

   function automatic logic [31:0] pick_step();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) begin
         return 32'h0;
      end else if (roll < 20) begin
         return 32'h8000_0000;   // half turn, top of range
      end else if (roll < 40) begin
         return $urandom_range(32'h0100_0000);
      end
      return $urandom & 32'h7FFF_FFFF;
   endfunction

   function automatic logic [31:0] pick_offset();
      int roll;
      roll = $urandom_range(99);
      if (roll < 10) begin
         return 32'h0;
      end else if (roll < 20) begin
         return 32'hFFFF_FFFF;
      end
      return $urandom;
   endfunction

   // weight rides in the low half; the upper half is junk the block drops
   function automatic logic [31:0] pick_weight_word();
      int          roll;
      logic [31:0] r;
      roll = $urandom_range(99);
      r    = $urandom;
      if (roll < 15) begin
         r[15:0] = 16'h7FFF;
      end else if (roll < 30) begin
         r[15:0] = 16'h8000;
      end else if (roll < 40) begin
         r[15:0] = 16'h0000;
      end
      return r;
   endfunction

   task automatic send_word(logic func, logic [31:0] step, logic [31:0] offset,
                            logic [31:0] phase, int gap, bit fixed,
                            logic [SAMPLE_W-1:0] fx_sample, logic fx_clip);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tuser    <= func;
      req_tdata    <= {phase, offset, step};
      fixed_valid  <= fixed;
      fixed_sample <= fx_sample;
      fixed_clip   <= fx_clip;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // drain: nothing owed, then room for a load word still in flight
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_mix.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic plan_row_type word_row(logic func, logic [31:0] step,
                                             logic [31:0] offset, logic [31:0] phase);
      plan_row_type r;
      r = '{default: '0};
      r.func   = func;
      r.step   = step;
      r.offset = offset;
      r.phase  = phase;
      return r;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_INDEX_W-1:0] idx, logic [31:0] val);
      plan_row_type r;
      r = '{default: '0};
      r.is_csr = 1'b1;
      r.idx    = idx;
      r.val    = val;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : driver
      plan_row_type plan[$];
      plan_row_type row;
      bit           burst;
      int           roll;

      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tuser     = FUNC_TICK;
      req_tdata     = '0;
      csr_valid     = 1'b0;
      csr_index     = CSR_STEP_OSC1;
      csr_data      = '0;
      fixed_valid   = 1'b0;
      fixed_sample  = '0;
      fixed_clip    = 1'b0;
      long_hold_req = 1'b0;
      fail_count    = 0;

      // directed part
      // first tick after reset: all phases and offsets zero, sine of zero
      row = word_row(FUNC_TICK, 32'h0, 32'h0, 32'h0);
      row.fixed = 1'b1;
      row.fx_sample = '0;
      row.fx_clip = 1'b0;
      plan.push_back(row);
      // largest step, offset one tick below a full turn
      plan.push_back(word_row(FUNC_TICK, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0));
      plan.push_back(word_row(FUNC_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      plan.push_back(word_row(FUNC_TICK, 32'h7FFF_FFFF, 32'h4000_0000, 32'hFFFF_FFFF));
      plan.push_back(word_row(FUNC_LOAD, 32'h0, 32'h0, 32'h0));
      plan.push_back(word_row(FUNC_TICK, 32'h1, 32'h8000_0000, 32'h0));
      plan.push_back(word_row(FUNC_TICK, 32'h0, 32'hC000_0000, 32'h5555_5555));
      // full-scale weights, voice 0 loaded onto a peak: the first tick clips high
      plan.push_back(csr_row(CSR_STEP_OSC1, 32'h0));
      plan.push_back(csr_row(CSR_STEP_OSC2, 32'h8000_0000));
      plan.push_back(csr_row(CSR_OFFSET_OSC1, 32'hFFFF_FFFF));
      plan.push_back(csr_row(CSR_OFFSET_OSC2, 32'h4000_0000));
      plan.push_back(csr_row(CSR_WEIGHT_OSC0, 32'h0000_7FFF));
      plan.push_back(csr_row(CSR_WEIGHT_OSC1, 32'h0000_7FFF));
      plan.push_back(csr_row(CSR_WEIGHT_OSC2, 32'h0000_7FFF));
      plan.push_back(word_row(FUNC_LOAD, 32'h0, 32'h0, 32'h4000_0000));
      plan.push_back(word_row(FUNC_TICK, 32'h0, 32'h0, 32'h0));
      plan.push_back(word_row(FUNC_TICK, 32'h8000_0000, 32'h4000_0000, 32'h0));
      // most negative weights, junk in the upper half, spare slot written
      plan.push_back(csr_row(CSR_WEIGHT_OSC0, 32'hABCD_8000));
      plan.push_back(csr_row(CSR_WEIGHT_OSC1, 32'h1234_8000));
      plan.push_back(csr_row(CSR_WEIGHT_OSC2, 32'hFFFF_8000));
      plan.push_back(csr_row(CSR_SPARE, 32'hFFFF_FFFF));
      plan.push_back(word_row(FUNC_TICK, 32'h0, 32'h4000_0000, 32'h0));
      plan.push_back(word_row(FUNC_LOAD, 32'h0, 32'h0, 32'hC000_0000));
      plan.push_back(word_row(FUNC_TICK, 32'h0000_0001, 32'h0, 32'h0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].is_csr) begin
            wait_idle();
            csr_write(plan[r].idx, plan[r].val);
         end else begin
            send_word(plan[r].func, plan[r].step, plan[r].offset, plan[r].phase, 0,
                      plan[r].fixed, plan[r].fx_sample, plan[r].fx_clip);
         end
      end

      // random part: fresh settings per phase, then a stream of words
      for (int p = 0; p < RAND_PHASES; p++) begin
         wait_idle();
         csr_write(CSR_STEP_OSC1, pick_step());
         csr_write(CSR_STEP_OSC2, pick_step());
         csr_write(CSR_OFFSET_OSC1, pick_offset());
         csr_write(CSR_OFFSET_OSC2, pick_offset());
         csr_write(CSR_WEIGHT_OSC0, pick_weight_word());
         csr_write(CSR_WEIGHT_OSC1, pick_weight_word());
         csr_write(CSR_WEIGHT_OSC2, pick_weight_word());
         if (p == 1) begin
            csr_write(CSR_SPARE, $urandom);
         end
         burst = (p % 3 == 2);
         // back-to-back words against a stalled receiver: fills the output
         // register and must push back on req
         if (p == 2) begin
            long_hold_req = 1'b1;
         end
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            roll = $urandom_range(99);
            send_word((roll < 15) ? FUNC_LOAD : FUNC_TICK, pick_step(), pick_offset(),
                      $urandom, pick_gap(burst), 1'b0, '0, 1'b0);
         end
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // hang guard
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sine_oscillator_bank_mixer.f
hw/rtl/somo_pkg.sv
hw/rtl/somo_sine_rom.sv
hw/rtl/somo_mix_unit.sv
hw/rtl/sine_oscillator_bank_mixer.sv
verif/testbench.sv
